// ===== rtl/core/llpi_pkg.sv =====
// ----------------------------------------------------------------------------
// llpi_pkg
// Shared constants for the light level interpolation core: field widths,
// the ten-point calibration curve and per-segment reciprocal tables.
// ----------------------------------------------------------------------------
package llpi_pkg;

  // field widths
  localparam int CODE_W = 10;
  localparam int REF_W  = 13;
  localparam int PCT_W  = 7;

  // register reset value
  localparam logic [REF_W-1:0] REF_RESET = 13'd5000;

  // calibration curve
  localparam int NUM_PTS = 10;
  localparam int NUM_SEG = NUM_PTS - 1;
  localparam int SEG_W   = 4;
  localparam int CAL_W   = 12;
  localparam int X100_W  = 14;

  localparam logic [CAL_W-1:0] CAL_MV [NUM_PTS] = '{
    12'd5, 12'd25, 12'd50, 12'd98, 12'd238,
    12'd455, 12'd833, 12'd1667, 12'd2500, 12'd3333
  };

  localparam logic [X100_W-1:0] CAL_X100 [NUM_PTS] = '{
    14'd0, 14'd1111, 14'd2222, 14'd3333, 14'd4444,
    14'd5556, 14'd6667, 14'd7778, 14'd8889, 14'd10000
  };

  // segment widths in millivolts and intensity
  localparam int OFF_W = 10;
  localparam int DI_W  = 11;

  localparam logic [OFF_W-1:0] SEG_DV [NUM_SEG] = '{
    OFF_W'(CAL_MV[1] - CAL_MV[0]), OFF_W'(CAL_MV[2] - CAL_MV[1]),
    OFF_W'(CAL_MV[3] - CAL_MV[2]), OFF_W'(CAL_MV[4] - CAL_MV[3]),
    OFF_W'(CAL_MV[5] - CAL_MV[4]), OFF_W'(CAL_MV[6] - CAL_MV[5]),
    OFF_W'(CAL_MV[7] - CAL_MV[6]), OFF_W'(CAL_MV[8] - CAL_MV[7]),
    OFF_W'(CAL_MV[9] - CAL_MV[8])
  };

  localparam logic [DI_W-1:0] SEG_DI [NUM_SEG] = '{
    DI_W'(CAL_X100[1] - CAL_X100[0]), DI_W'(CAL_X100[2] - CAL_X100[1]),
    DI_W'(CAL_X100[3] - CAL_X100[2]), DI_W'(CAL_X100[4] - CAL_X100[3]),
    DI_W'(CAL_X100[5] - CAL_X100[4]), DI_W'(CAL_X100[6] - CAL_X100[5]),
    DI_W'(CAL_X100[7] - CAL_X100[6]), DI_W'(CAL_X100[8] - CAL_X100[7]),
    DI_W'(CAL_X100[9] - CAL_X100[8])
  };

  // interpolation product and its reciprocal divide
  localparam int P2_W         = 20;
  localparam int INTERP_SHIFT = 20;
  localparam int RECIP2_W     = 16;
  localparam int INTERP_W     = 11;
  localparam int INTERP_ONE   = 1 << INTERP_SHIFT;

  localparam logic [RECIP2_W-1:0] SEG_RECIP [NUM_SEG] = '{
    RECIP2_W'(INTERP_ONE / int'(SEG_DV[0])), RECIP2_W'(INTERP_ONE / int'(SEG_DV[1])),
    RECIP2_W'(INTERP_ONE / int'(SEG_DV[2])), RECIP2_W'(INTERP_ONE / int'(SEG_DV[3])),
    RECIP2_W'(INTERP_ONE / int'(SEG_DV[4])), RECIP2_W'(INTERP_ONE / int'(SEG_DV[5])),
    RECIP2_W'(INTERP_ONE / int'(SEG_DV[6])), RECIP2_W'(INTERP_ONE / int'(SEG_DV[7])),
    RECIP2_W'(INTERP_ONE / int'(SEG_DV[8]))
  };

  // rounding to whole percent, divide by 100 as multiply and shift
  localparam int VAL_W         = 14;
  localparam int PERCENT_SCALE = 100;
  localparam int ROUND_HALF    = 50;
  localparam int PCT_SHIFT     = 19;
  localparam int PCT_RECIP_W   = 13;
  localparam int PCT_PROD_W    = VAL_W + PCT_RECIP_W;
  localparam logic [PCT_RECIP_W-1:0] PCT_RECIP =
    PCT_RECIP_W'(((1 << PCT_SHIFT) / PERCENT_SCALE) + 1);
  localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(PERCENT_SCALE);

endpackage

// ===== rtl/core/light_level_piecewise_interp_core.sv =====
// ----------------------------------------------------------------------------
// light_level_piecewise_interp_core
// Timing: the accept sets s1_valid, the valid walks s1_valid through s8_valid, and
// done is registered from s8_valid at the same edge that registers the result.
// Throughput: one transaction per cycle; busy is never raised, and the nine
// register stages (two reciprocal-multiply dividers) never stall.
// Reset: synchronous rst clears all stage valids and done, and loads
// reference_millivolts with 5000. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module light_level_piecewise_interp_core
  import llpi_pkg::*;
#(
  parameter int ADC_STEPS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [CODE_W-1:0] adc_code,
  input  logic              cfg_we,
  input  logic [REF_W-1:0]  cfg_wdata,
  output logic              done,
  output logic [PCT_W-1:0]  intensity_percent
);

  // millivolt scaling: mv = code * ref / (ADC_STEPS - 1)
  localparam int DIVISOR  = ADC_STEPS - 1;
  localparam int DIV_W    = $clog2(ADC_STEPS);
  localparam int PROD_W   = CODE_W + REF_W;
  localparam int RECIP1_W = PROD_W + 2;
  localparam int PRODM_W  = PROD_W + RECIP1_W;
  localparam int MV_SHIFT = PROD_W + DIV_W;
  localparam logic [63:0] MV_RECIP_FULL = (64'd1 << MV_SHIFT) / 64'(DIVISOR);
  localparam logic [RECIP1_W-1:0] MV_RECIP = MV_RECIP_FULL[RECIP1_W-1:0];
  localparam int MV_MAX   = ((2 ** CODE_W - 1) * (2 ** REF_W - 1)) / DIVISOR;
  localparam int MV_RAW_W = $clog2(MV_MAX + 1);
  localparam int MV_W     = (MV_RAW_W > CAL_W) ? MV_RAW_W : CAL_W;
  localparam int QD_W     = MV_W + DIV_W;
  localparam int P2M_W    = P2_W + RECIP2_W;

  logic [REF_W-1:0] reference_millivolts;

  logic                s1_valid;
  logic [PROD_W-1:0]   s1_prod;
  logic                s2_valid;
  logic [PROD_W-1:0]   s2_prod;
  logic [MV_W-1:0]     s2_qa;
  logic                s3_valid;
  logic [MV_W-1:0]     s3_mv;
  logic                s4_valid;
  logic                s4_lo;
  logic                s4_hi;
  logic [SEG_W-1:0]    s4_seg;
  logic [OFF_W-1:0]    s4_offset;
  logic                s5_valid;
  logic                s5_lo;
  logic                s5_hi;
  logic [SEG_W-1:0]    s5_seg;
  logic [P2_W-1:0]     s5_p2;
  logic                s6_valid;
  logic                s6_lo;
  logic                s6_hi;
  logic [SEG_W-1:0]    s6_seg;
  logic [P2_W-1:0]     s6_p2;
  logic [INTERP_W-1:0] s6_qb;
  logic                s7_valid;
  logic                s7_lo;
  logic                s7_hi;
  logic [SEG_W-1:0]    s7_seg;
  logic [INTERP_W-1:0] s7_interp;
  logic                s8_valid;
  logic                s8_lo;
  logic                s8_hi;
  logic [PCT_PROD_W-1:0] s8_t;

  logic [PRODM_W-1:0]  qa_wide;
  logic [QD_W-1:0]     qa_times_d;
  logic [PROD_W-1:0]   mv_rem;
  logic [SEG_W-1:0]    seg_next;
  logic [P2M_W-1:0]    qb_wide;
  logic [P2_W-1:0]     qb_times_dv;
  logic [P2_W-1:0]     interp_rem;
  logic [VAL_W-1:0]    val_rounded;
  logic [PCT_W-1:0]    pct_next;

  // pipeline never stalls
  assign busy = 1'b0;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      reference_millivolts <= REF_RESET;
    end else if (cfg_we) begin
      reference_millivolts <= cfg_wdata;
    end
  end

  // valid chain and output strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
      s7_valid <= 1'b0;
      s8_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
      s7_valid <= s6_valid;
      s8_valid <= s7_valid;
      done     <= s8_valid;
    end
  end

  // stage 1: code times reference
  always_ff @(posedge clk) begin
    s1_prod <= PROD_W'(adc_code) * PROD_W'(reference_millivolts);
  end

  // stage 2: approximate quotient by reciprocal, low by at most one
  assign qa_wide = PRODM_W'(s1_prod) * PRODM_W'(MV_RECIP);

  always_ff @(posedge clk) begin
    s2_prod <= s1_prod;
    s2_qa   <= MV_W'(qa_wide >> MV_SHIFT);
  end

  // stage 3: remainder check fixes the quotient
  assign qa_times_d = QD_W'(s2_qa) * QD_W'(DIVISOR);
  assign mv_rem     = s2_prod - PROD_W'(qa_times_d);

  always_ff @(posedge clk) begin
    s3_mv <= s2_qa + MV_W'(mv_rem >= PROD_W'(DIVISOR));
  end

  // stage 4: clamps, segment search and offset into segment
  always_comb begin
    seg_next = SEG_W'(NUM_SEG - 1);
    for (int i = NUM_SEG - 2; i >= 0; i--) begin
      if (s3_mv <= MV_W'(CAL_MV[i+1])) begin
        seg_next = SEG_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    s4_lo     <= s3_mv <= MV_W'(CAL_MV[0]);
    s4_hi     <= s3_mv >= MV_W'(CAL_MV[NUM_PTS-1]);
    s4_seg    <= seg_next;
    s4_offset <= OFF_W'(s3_mv - MV_W'(CAL_MV[seg_next]));
  end

  // stage 5: offset times intensity span
  always_ff @(posedge clk) begin
    s5_lo  <= s4_lo;
    s5_hi  <= s4_hi;
    s5_seg <= s4_seg;
    s5_p2  <= P2_W'(s4_offset) * P2_W'(SEG_DI[s4_seg]);
  end

  // stage 6: approximate divide by segment width
  assign qb_wide = P2M_W'(s5_p2) * P2M_W'(SEG_RECIP[s5_seg]);

  always_ff @(posedge clk) begin
    s6_lo  <= s5_lo;
    s6_hi  <= s5_hi;
    s6_seg <= s5_seg;
    s6_p2  <= s5_p2;
    s6_qb  <= INTERP_W'(qb_wide >> INTERP_SHIFT);
  end

  // stage 7: remainder check on the interpolation quotient
  assign qb_times_dv = P2_W'(s6_qb) * P2_W'(SEG_DV[s6_seg]);
  assign interp_rem  = s6_p2 - qb_times_dv;

  always_ff @(posedge clk) begin
    s7_lo     <= s6_lo;
    s7_hi     <= s6_hi;
    s7_seg    <= s6_seg;
    s7_interp <= s6_qb + INTERP_W'(interp_rem >= P2_W'(SEG_DV[s6_seg]));
  end

  // stage 8: add segment base, round half up, scale toward percent
  assign val_rounded = VAL_W'(CAL_X100[s7_seg]) + VAL_W'(s7_interp) + VAL_W'(ROUND_HALF);

  always_ff @(posedge clk) begin
    s8_lo <= s7_lo;
    s8_hi <= s7_hi;
    s8_t  <= PCT_PROD_W'(val_rounded) * PCT_PROD_W'(PCT_RECIP);
  end

  // stage 9: clamp and register the result
  always_comb begin
    if (s8_lo) begin
      pct_next = '0;
    end else if (s8_hi) begin
      pct_next = PCT_MAX;
    end else begin
      pct_next = PCT_W'(s8_t >> PCT_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    intensity_percent <= pct_next;
  end

`ifndef SYNTH
  // every result comes from an earlier accepted transaction
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 9))
    else $error("result without matching transaction");

  // result stays in the percent range
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    done |-> intensity_percent <= PCT_MAX)
    else $error("intensity out of range");

  // both clamps cannot apply at once
  a_clamp_excl: assert property (@(posedge clk) disable iff (rst)
    s4_valid |-> !(s4_lo && s4_hi))
    else $error("low and high clamp both set");

  // an interior voltage stays within its segment, upper point included
  a_offset_bound: assert property (@(posedge clk) disable iff (rst)
    (s4_valid && !s4_lo && !s4_hi) |-> s4_offset <= SEG_DV[s4_seg])
    else $error("segment offset beyond segment width");

  // interpolated step never exceeds the segment span
  a_interp_bound: assert property (@(posedge clk) disable iff (rst)
    (s7_valid && !s7_lo && !s7_hi) |-> s7_interp <= SEG_DI[s7_seg])
    else $error("interpolation beyond segment span");
`endif

endmodule

// ===== dv/tb_light_level_piecewise_interp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_light_level_piecewise_interp_core
// Self-checking bench for the light level interpolation core. A queue-fed
// driver sends converter codes under several reference settings, and a
// monitor predicts the percent for every accepted transaction. It then
// checks each done strobe against the oldest prediction, in order.
// ----------------------------------------------------------------------------
module tb_light_level_piecewise_interp_core;
  import llpi_pkg::*;

  localparam int ADC_STEPS      = 1024;
  localparam int PIPE_LAT       = 9;
  localparam int SETTLE         = PIPE_LAT + 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RAND_PER_PHASE = 140;
  localparam int NUM_PHASES     = 7;
  localparam logic [REF_W-1:0] VREF_RESET = 13'd5000;
  localparam longint unsigned STEP_DIV = (ADC_STEPS > 1) ? ADC_STEPS - 1 : 1;

  // calibration curve, millivolts and intensity x100
  localparam int unsigned KNEE_MV [10] = '{
    5, 25, 50, 98, 238, 455, 833, 1667, 2500, 3333
  };
  localparam int unsigned KNEE_X100 [10] = '{
    0, 1111, 2222, 3333, 4444, 5556, 6667, 7778, 8889, 10000
  };

  typedef struct {
    logic [CODE_W-1:0] code;
    logic [REF_W-1:0]  vref;
    logic [PCT_W-1:0]  pct;
  } pct_expect_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [CODE_W-1:0] adc_code = '0;
  logic              cfg_we = 1'b0;
  logic [REF_W-1:0]  cfg_wdata = '0;
  logic              done;
  logic [PCT_W-1:0]  intensity_percent;

  logic [CODE_W-1:0] pending_codes[$];
  pct_expect_t       pct_expected[$];
  logic [REF_W-1:0]  vref_model = VREF_RESET;
  logic [REF_W-1:0]  cur_vref = VREF_RESET;
  int                send_idle_pct = 0;
  bit                xact_taken = 1'b0;
  bit                quiet = 1'b0;
  int                idle_run = 0;
  int                n_samples = 0;
  int                n_checked = 0;
  int                n_errors = 0;
  int                n_settings = 1;

  light_level_piecewise_interp_core #(
    .ADC_STEPS(ADC_STEPS)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .adc_code         (adc_code),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .done             (done),
    .intensity_percent(intensity_percent)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // code scaled to millivolts, full width
  function automatic longint unsigned code_to_mv(input logic [CODE_W-1:0] code,
                                                 input logic [REF_W-1:0] vref);
    return (longint'(code) * longint'(vref)) / STEP_DIV;
  endfunction

  // expected percent from the calibration curve
  function automatic logic [PCT_W-1:0] light_pct(input logic [CODE_W-1:0] code,
                                                 input logic [REF_W-1:0] vref);
    longint unsigned mv;
    longint unsigned span;
    longint unsigned rise;
    longint unsigned val;
    mv = code_to_mv(code, vref);
    if (mv <= KNEE_MV[0]) return '0;
    if (mv >= KNEE_MV[9]) return PCT_W'(100);
    for (int s = 0; s < 9; s++) begin
      if (mv <= KNEE_MV[s+1]) begin
        span = KNEE_MV[s+1] - KNEE_MV[s];
        rise = KNEE_X100[s+1] - KNEE_X100[s];
        val  = KNEE_X100[s] + ((mv - KNEE_MV[s]) * rise) / span;
        return PCT_W'((val + 50) / 100);
      end
    end
    return PCT_W'(100);
  endfunction

  // smallest code that reaches a given voltage, or full scale
  function automatic logic [CODE_W-1:0] first_code(input longint unsigned mv,
                                                   input logic [REF_W-1:0] vref);
    for (int c = 0; c < (1 << CODE_W); c++) begin
      if (code_to_mv(CODE_W'(c), vref) >= mv) return CODE_W'(c);
    end
    return '1;
  endfunction

  // driver: present a code, hold it until the transaction is taken
  always @(negedge clk) begin
    if (rst) begin
      start    <= 1'b0;
      adc_code <= '0;
    end else if (!start || xact_taken) begin
      if (pending_codes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        start    <= 1'b1;
        adc_code <= pending_codes.pop_front();
      end else begin
        start    <= 1'b0;
        adc_code <= CODE_W'($urandom);
      end
    end
  end

  // monitor: predict on accept, check on done, watchdog
  always @(posedge clk) begin
    pct_expect_t want;
    if (rst) begin
      vref_model = VREF_RESET;
      xact_taken = 1'b0;
      quiet      = 1'b0;
      idle_run   = 0;
    end else begin
      xact_taken = start && !busy;
      if (xact_taken) begin
        want.code = adc_code;
        want.vref = vref_model;
        want.pct  = light_pct(adc_code, vref_model);
        pct_expected.push_back(want);
        n_samples++;
      end
      if (cfg_we) vref_model = cfg_wdata;
      if (done) begin
        if (pct_expected.size() == 0) begin
          if (n_errors < 10)
            $display("ERROR: unexpected result %0d at %0t", intensity_percent, $realtime);
          n_errors++;
        end else begin
          want = pct_expected.pop_front();
          n_checked++;
          if (intensity_percent !== want.pct) begin
            if (n_errors < 10)
              $display("ERROR: code %0d ref %0d mV: expected %0d%%, got %0d%%",
                       want.code, want.vref, want.pct, intensity_percent);
            n_errors++;
          end
        end
      end
      if (xact_taken || done) idle_run = 0;
      else idle_run++;
      if (idle_run >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", idle_run);
        $display("Simulation FAILED");
        $finish;
      end
      quiet = (pending_codes.size() == 0) && !start && (pct_expected.size() == 0);
    end
  end

  // hold off until every expected result is back, then let the pipe settle
  task automatic wait_quiet();
    do @(negedge clk); while (!quiet);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_vref(input logic [REF_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_vref  = v;
    n_settings++;
  endtask

  // zero, full scale, alternating bits, and both sides of every calibration point
  task automatic queue_directed();
    logic [CODE_W-1:0] c;
    pending_codes.push_back('0);
    pending_codes.push_back('1);
    pending_codes.push_back(10'h155);
    pending_codes.push_back(10'h2aa);
    for (int k = 0; k < 10; k++) begin
      c = first_code(KNEE_MV[k], cur_vref);
      pending_codes.push_back(c);
      if (c != 0) pending_codes.push_back(c - 1'b1);
    end
  endtask

  // mostly uniform codes, some close to calibration points, some at the rails
  task automatic queue_random(input int n);
    int               pick;
    int               c;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(9);
      if (pick <= 5) begin
        c = $urandom_range((1 << CODE_W) - 1);
      end else if (pick <= 8) begin
        c = int'(first_code(KNEE_MV[$urandom_range(9)], cur_vref)) + $urandom_range(4) - 2;
        if (c < 0) c = 0;
        if (c > (1 << CODE_W) - 1) c = (1 << CODE_W) - 1;
      end else begin
        c = $urandom_range(1) ? (1 << CODE_W) - 1 : 0;
      end
      pending_codes.push_back(CODE_W'(c));
    end
  endtask

  // stimulus sequence
  initial begin
    logic [REF_W-1:0] next_vref;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct = (ph < 3) ? 28 : (ph < 5) ? 81 : 0;
      if (ph > 0) begin
        case (ph)
          1:       next_vref = '0;
          2:       next_vref = '1;
          3:       next_vref = REF_W'(1);
          4:       next_vref = REF_W'(3300);
          5:       next_vref = REF_W'($urandom_range(8190, 2));
          default: next_vref = VREF_RESET;
        endcase
        wait_quiet();
        write_vref(next_vref);
      end
      if (ph == 0) queue_directed();
      if (ph == 5) begin
        queue_random(RAND_PER_PHASE / 2);
        wait_quiet();
        queue_random(RAND_PER_PHASE / 2);
      end else begin
        queue_random(RAND_PER_PHASE);
      end
    end
    wait_quiet();
    if (pct_expected.size() != 0) begin
      $display("ERROR: %0d results never arrived", pct_expected.size());
      n_errors += pct_expected.size();
    end
    $display("checked %0d results from %0d samples across %0d reference settings",
             n_checked, n_samples, n_settings);
    $display("references spanned 0 to 8191 mV with idle and back-to-back traffic, %0d errors",
             n_errors);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
